>>> hw/rtl/yuvrgb_pkg.sv
package yuvrgb_pkg;

   // Widths of the fixed-point sum: 297*(Y-16) plus the chroma terms stays well
   // inside a 20-bit signed value.
   localparam int SumWidth = 20;

   localparam logic [15:0] HdWidthMin = 16'd1920;

   localparam logic signed [SumWidth-1:0] LumaGain   = 20'sd297;
   localparam logic signed [SumWidth-1:0] LumaOffset = 20'sd16;
   localparam logic signed [SumWidth-1:0] RoundBias  = 20'sd127;
   localparam logic [7:0]                 ChromaMid  = 8'd128;

   // BT.709 coefficients.
   localparam logic signed [SumWidth-1:0] HdCrToRed   = 20'sd457;
   localparam logic signed [SumWidth-1:0] HdCbToGreen = 20'sd54;
   localparam logic signed [SumWidth-1:0] HdCrToGreen = 20'sd136;
   localparam logic signed [SumWidth-1:0] HdCbToBlue  = 20'sd539;

   // BT.601 coefficients.
   localparam logic signed [SumWidth-1:0] SdCrToRed   = 20'sd407;
   localparam logic signed [SumWidth-1:0] SdCbToGreen = 20'sd100;
   localparam logic signed [SumWidth-1:0] SdCrToGreen = 20'sd207;
   localparam logic signed [SumWidth-1:0] SdCbToBlue  = 20'sd514;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Floor of t/256, clamped to 0..255.
   function automatic logic [7:0] clamp_channel(logic signed [SumWidth-1:0] t);
      logic [SumWidth-9:0] q;
      q = t[SumWidth-1:8];
      if (t[SumWidth-1]) begin
         return 8'd0;
      end else if (q > 12'd255) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

   // Removes the chroma midpoint and sign-extends to the sum width.
   function automatic logic signed [SumWidth-1:0] center_chroma(logic [7:0] c);
      logic [8:0] diff;
      diff = {1'b0, c} - {1'b0, ChromaMid};
      return {{(SumWidth-9){diff[8]}}, diff};
   endfunction

   // Both coefficient sets are formed as constant products and the result is
   // selected afterwards, so no general multiplier is needed.
   function automatic rgb_type convert_pixel(logic [7:0] luma,
                                             logic signed [SumWidth-1:0] u,
                                             logic signed [SumWidth-1:0] v,
                                             logic hd);
      logic signed [SumWidth-1:0] luma_ext;
      logic signed [SumWidth-1:0] base;
      logic signed [SumWidth-1:0] r;
      logic signed [SumWidth-1:0] g;
      logic signed [SumWidth-1:0] b;
      rgb_type                    pix;
      luma_ext = {{(SumWidth-8){1'b0}}, luma};
      base = LumaGain * (luma_ext - LumaOffset) + RoundBias;
      if (hd) begin
         r = base + HdCrToRed * v;
         g = base - HdCbToGreen * u - HdCrToGreen * v;
         b = base + HdCbToBlue * u;
      end else begin
         r = base + SdCrToRed * v;
         g = base - SdCbToGreen * u - SdCrToGreen * v;
         b = base + SdCbToBlue * u;
      end
      pix.red   = clamp_channel(r);
      pix.green = clamp_channel(g);
      pix.blue  = clamp_channel(b);
      return pix;
   endfunction

endpackage

>>> hw/rtl/yuv422_to_rgb_converter_core.sv
// UYVY 4:2:2 to RGB converter core.
//
// The req_ channel carries one macropixel per item (Cb, first luma, Cr,
// second luma). The rsp_ channel returns one item holding two RGB pixels
// that share the chroma pair. Both channels use a valid/ready handshake.
// The csr_ channel writes the frame width; a width of 1920 or more selects
// BT.709 coefficients, anything smaller selects BT.601. It should only be
// written while no item is in flight.
//
// An item accepted at one clock edge sits in the input register, and the
// result register loads its conversion once it is empty or its item leaves.
// rsp_valid rises when the result register holds the item. Throughput is one
// item per clock while rsp_ready stays high; the single conversion stage
// between the two registers sets that figure. When the receiver stalls,
// the result register holds its item and the input register can still take
// one more item; after that req_ready drops until the receiver takes the result.
//
// Reset empties both registers and loads a frame width of 1920 (BT.709).
// Alpha is not produced here.
module yuv422_to_rgb_converter_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_cb,
   input  logic [7:0]  req_luma_first,
   input  logic [7:0]  req_cr,
   input  logic [7:0]  req_luma_second,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_first,
   output logic [7:0]  rsp_green_first,
   output logic [7:0]  rsp_blue_first,
   output logic [7:0]  rsp_red_second,
   output logic [7:0]  rsp_green_second,
   output logic [7:0]  rsp_blue_second,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_frame_width
);

   // Configuration register.
   logic [15:0] frame_width_ff;
   logic [15:0] frame_width_in;

   // Input register stage.
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [7:0]  s1_cb_ff;
   logic [7:0]  s1_luma_first_ff;
   logic [7:0]  s1_cr_ff;
   logic [7:0]  s1_luma_second_ff;

   // Result register stage.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   yuvrgb_pkg::rgb_type pix_first_ff;
   yuvrgb_pkg::rgb_type pix_second_ff;
   yuvrgb_pkg::rgb_type pix_first_in;
   yuvrgb_pkg::rgb_type pix_second_in;

   logic        req_fire;
   logic        s1_move;
   logic        rsp_free;
   logic        hd_mode;
   logic signed [yuvrgb_pkg::SumWidth-1:0] u_centered;
   logic signed [yuvrgb_pkg::SumWidth-1:0] v_centered;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;

   // The result register can load when it is empty or its item leaves now.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !rsp_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   assign frame_width_in = (csr_valid && csr_ready) ? csr_frame_width : frame_width_ff;

   // Conversion between the input and result registers.
   assign hd_mode    = frame_width_ff >= yuvrgb_pkg::HdWidthMin;
   assign u_centered = yuvrgb_pkg::center_chroma(s1_cb_ff);
   assign v_centered = yuvrgb_pkg::center_chroma(s1_cr_ff);

   always_comb begin
      pix_first_in  = yuvrgb_pkg::convert_pixel(s1_luma_first_ff, u_centered,
                                                v_centered, hd_mode);
      pix_second_in = yuvrgb_pkg::convert_pixel(s1_luma_second_ff, u_centered,
                                                v_centered, hd_mode);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= yuvrgb_pkg::HdWidthMin;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_width_ff <= frame_width_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers load only when their stage advances.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cb_ff          <= req_cb;
         s1_luma_first_ff  <= req_luma_first;
         s1_cr_ff          <= req_cr;
         s1_luma_second_ff <= req_luma_second;
      end
      if (s1_move) begin
         pix_first_ff  <= pix_first_in;
         pix_second_ff <= pix_second_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_first    = pix_first_ff.red;
   assign rsp_green_first  = pix_first_ff.green;
   assign rsp_blue_first   = pix_first_ff.blue;
   assign rsp_red_second   = pix_second_ff.red;
   assign rsp_green_second = pix_second_ff.green;
   assign rsp_blue_second  = pix_second_ff.blue;

`ifndef ASSERT_OFF
   // An accepted item always lands in the input register.
   a_req_to_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item missing from input register");

   // An item leaving the input register always lands in the result register.
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid)
      else $error("converted item missing from result register");

   // Backpressure only when both registers are full.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while a register is free");

   // A configuration write takes effect on the next cycle.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> frame_width_ff == $past(csr_frame_width))
      else $error("frame width write lost");

   // Reset loads the HD default width.
   a_reset_width: assert property (@(posedge clock)
      $past(reset) |-> frame_width_ff == yuvrgb_pkg::HdWidthMin)
      else $error("frame width not at default after reset");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

   // Fixed-point conversion constants. The luma term, rounding bias and
   // chroma midpoint are shared by both standards.
   localparam int LumaScale    = 297;
   localparam int LumaFloor    = 16;
   localparam int ChromaCenter = 128;
   localparam int RoundingTerm = 127;
   localparam int HdMinWidth   = 1920;

   // BT.709 coefficients.
   localparam int Bt709CrRed   = 457;
   localparam int Bt709CbGreen = 54;
   localparam int Bt709CrGreen = 136;
   localparam int Bt709CbBlue  = 539;

   // BT.601 coefficients.
   localparam int Bt601CrRed   = 407;
   localparam int Bt601CbGreen = 100;
   localparam int Bt601CrGreen = 207;
   localparam int Bt601CbBlue  = 514;

   localparam int NumDirected  = 18;
   localparam int NumPhases    = 7;
   localparam int PhaseItems   = 156;
   localparam int DrainTail    = 8;
   localparam int DrainLimit   = 4000;

   typedef struct packed {
      logic [7:0] cb;
      logic [7:0] luma_first;
      logic [7:0] cr;
      logic [7:0] luma_second;
   } macropixel_type;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
   } rgb_pair_type;

   // A row of the directed table. Rows with neutral chroma come out gray, so
   // their expected levels are written straight into the table.
   typedef struct packed {
      macropixel_type px;
      bit             known_gray;
      logic [7:0]     gray_first;
      logic [7:0]     gray_second;
   } directed_row_type;

   typedef enum int {
      StyleUniform,
      StyleCorner,
      StyleNearGray
   } byte_style_type;

   logic        clock;
   logic        reset;

   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_cb;
   logic [7:0]  req_luma_first;
   logic [7:0]  req_cr;
   logic [7:0]  req_luma_second;

   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_red_first;
   logic [7:0]  rsp_green_first;
   logic [7:0]  rsp_blue_first;
   logic [7:0]  rsp_red_second;
   logic [7:0]  rsp_green_second;
   logic [7:0]  rsp_blue_second;

   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_frame_width;

   // Prediction that goes with the macropixel currently on the req_ port.
   rgb_pair_type offered_pixels;
   rgb_pair_type pending_pixels [$];

   // The sender keeps its own copy of the frame width register.
   logic [15:0] model_frame_width;
   bit          idle_enable;

   int          mismatch_count;
   int          macropixels_accepted;
   int          pairs_checked;
   int          bt709_count;
   int          bt601_count;
   int          width_settings;

   yuv422_to_rgb_converter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cb           (req_cb),
      .req_luma_first   (req_luma_first),
      .req_cr           (req_cr),
      .req_luma_second  (req_luma_second),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_first    (rsp_red_first),
      .rsp_green_first  (rsp_green_first),
      .rsp_blue_first   (rsp_blue_first),
      .rsp_red_second   (rsp_red_second),
      .rsp_green_second (rsp_green_second),
      .rsp_blue_second  (rsp_blue_second),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frame_width  (csr_frame_width)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Floor of the sum over 256, held to the 0..255 range. A negative sum
   // always lands at zero, since its floor is negative.
   function automatic logic [7:0] to_channel(int acc);
      int q;
      if (acc < 0) begin
         return 8'd0;
      end
      q = acc >>> 8;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic logic [23:0] pixel_color(logic [7:0] luma, int u, int v, bit hd);
      int base;
      base = LumaScale * (int'(luma) - LumaFloor) + RoundingTerm;
      if (hd) begin
         return {to_channel(base + Bt709CrRed * v),
                 to_channel(base - Bt709CbGreen * u - Bt709CrGreen * v),
                 to_channel(base + Bt709CbBlue * u)};
      end
      return {to_channel(base + Bt601CrRed * v),
              to_channel(base - Bt601CbGreen * u - Bt601CrGreen * v),
              to_channel(base + Bt601CbBlue * u)};
   endfunction

   // Both pixels of a macropixel share the centered chroma pair.
   function automatic rgb_pair_type predict_rgb_pair(macropixel_type px, logic [15:0] width);
      int u;
      int v;
      bit hd;
      u  = int'(px.cb) - ChromaCenter;
      v  = int'(px.cr) - ChromaCenter;
      hd = int'(width) >= HdMinWidth;
      return {pixel_color(px.luma_first, u, v, hd), pixel_color(px.luma_second, u, v, hd)};
   endfunction

   function automatic logic [7:0] pick_byte(byte_style_type style);
      logic [7:0] corners [6];
      corners = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd240};
      case (style)
         StyleCorner: begin
            return corners[$urandom_range(0, 5)];
         end
         StyleNearGray: begin
            return 8'($urandom_range(104, 152));
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Chroma and luma draw their styles separately, so corners, near-gray
   // chroma and fully random bytes all mix with one another.
   function automatic macropixel_type random_macropixel();
      macropixel_type px;
      byte_style_type chroma_style;
      byte_style_type luma_style;
      chroma_style   = byte_style_type'($urandom_range(0, 2));
      luma_style     = ($urandom_range(0, 3) == 0) ? StyleCorner : StyleUniform;
      px.cb          = pick_byte(chroma_style);
      px.cr          = pick_byte(chroma_style);
      px.luma_first  = pick_byte(luma_style);
      px.luma_second = pick_byte(luma_style);
      return px;
   endfunction

   task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Called at a falling edge. The item may be preceded by a gap, and the
   // task returns at the falling edge that follows its acceptance.
   task automatic offer_macropixel(macropixel_type px, rgb_pair_type want);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cb          <= px.cb;
      req_luma_first  <= px.luma_first;
      req_cr          <= px.cr;
      req_luma_second <= px.luma_second;
      offered_pixels  <= want;
      if (int'(model_frame_width) >= HdMinWidth) begin
         bt709_count++;
      end else begin
         bt601_count++;
      end
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random_macropixel();
      macropixel_type px;
      px = random_macropixel();
      offer_macropixel(px, predict_rgb_pair(px, model_frame_width));
   endtask

   // Holds the sender off until every outstanding pair has come back. Every
   // macropixel yields exactly one pair, so an empty queue means the core is
   // idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
   endtask

   task automatic write_frame_width(logic [15:0] width);
      drain_results();
      csr_valid       <= 1'b1;
      csr_frame_width <= width;
      do @(posedge clock); while (!csr_ready);
      model_frame_width = width;
      width_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: ready is dropped in random bursts while idling is enabled.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // Monitor: an accepted macropixel queues its prediction, and an accepted
   // result is compared against the oldest one. The push comes first, which
   // keeps the queue order right even if both happen on the same edge.
   always @(posedge clock) begin : monitor
      rgb_pair_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_pixels.push_back(offered_pixels);
            macropixels_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("rsp item with no macropixel outstanding");
               mismatch_count++;
            end else begin
               want = pending_pixels.pop_front();
               check_channel("red_first",    want.red_first,    rsp_red_first);
               check_channel("green_first",  want.green_first,  rsp_green_first);
               check_channel("blue_first",   want.blue_first,   rsp_blue_first);
               check_channel("red_second",   want.red_second,   rsp_red_second);
               check_channel("green_second", want.green_second, rsp_green_second);
               check_channel("blue_second",  want.blue_second,  rsp_blue_second);
               pairs_checked++;
            end
         end
      end
   end

   // Stimulus.
   initial begin : stimulus
      directed_row_type directed_rows [NumDirected];
      logic [15:0]      phase_widths [NumPhases];
      rgb_pair_type     want;
      int               wait_cycles;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cb          = 8'd0;
      req_luma_first  = 8'd0;
      req_cr          = 8'd0;
      req_luma_second = 8'd0;
      csr_valid       = 1'b0;
      csr_frame_width = 16'd0;
      offered_pixels  = '0;
      idle_enable     = 1'b1;
      mismatch_count  = 0;
      macropixels_accepted = 0;
      pairs_checked   = 0;
      bt709_count     = 0;
      bt601_count     = 0;
      width_settings  = 1;

      // The core comes out of reset with a width of 1920, which is BT.709.
      model_frame_width = 16'd1920;

      // Neutral chroma rows check the luma path alone: black and white
      // levels, the first step above black, the step into saturation, and
      // luma below 16, which drives the sum negative. The colored rows hit
      // the chroma extremes, where channels saturate at both ends.
      directed_rows = '{
         '{'{8'd128, 8'd16,  8'd128, 8'd235}, 1'b1, 8'd0,   8'd254},
         '{'{8'd128, 8'd0,   8'd128, 8'd255}, 1'b1, 8'd0,   8'd255},
         '{'{8'd128, 8'd128, 8'd128, 8'd128}, 1'b1, 8'd130, 8'd130},
         '{'{8'd128, 8'd255, 8'd128, 8'd0},   1'b1, 8'd255, 8'd0},
         '{'{8'd128, 8'd17,  8'd128, 8'd16},  1'b1, 8'd1,   8'd0},
         '{'{8'd128, 8'd234, 8'd128, 8'd236}, 1'b1, 8'd253, 8'd255},
         '{'{8'd0,   8'd0,   8'd0,   8'd0},   1'b0, 8'd0,   8'd0},
         '{'{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, 8'd0,   8'd0},
         '{'{8'd0,   8'd255, 8'd255, 8'd0},   1'b0, 8'd0,   8'd0},
         '{'{8'd255, 8'd0,   8'd0,   8'd255}, 1'b0, 8'd0,   8'd0},
         '{'{8'd0,   8'd128, 8'd255, 8'd128}, 1'b0, 8'd0,   8'd0},
         '{'{8'd255, 8'd128, 8'd0,   8'd128}, 1'b0, 8'd0,   8'd0},
         '{'{8'd170, 8'd85,  8'd170, 8'd85},  1'b0, 8'd0,   8'd0},
         '{'{8'd85,  8'd170, 8'd85,  8'd170}, 1'b0, 8'd0,   8'd0},
         '{'{8'd0,   8'd235, 8'd255, 8'd16},  1'b0, 8'd0,   8'd0},
         '{'{8'd255, 8'd16,  8'd0,   8'd235}, 1'b0, 8'd0,   8'd0},
         '{'{8'd16,  8'd240, 8'd240, 8'd16},  1'b0, 8'd0,   8'd0},
         '{'{8'd240, 8'd16,  8'd16,  8'd240}, 1'b0, 8'd0,   8'd0}
      };

      // Width zero and width one sit below the BT.709 threshold, 1919 and
      // 1920 straddle it, and 65535 is the top of the register.
      phase_widths = '{16'd0, 16'd65535, 16'd1919, 16'd1, 16'd1920,
                       16'($urandom_range(1, 65535)), 16'($urandom_range(1, 1919))};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table under the reset width.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].known_gray) begin
            want = {{3{directed_rows[i].gray_first}}, {3{directed_rows[i].gray_second}}};
         end else begin
            want = predict_rgb_pair(directed_rows[i].px, model_frame_width);
         end
         offer_macropixel(directed_rows[i].px, want);
      end

      // Random traffic under the reset width, then one phase per setting.
      repeat (PhaseItems) send_random_macropixel();
      for (int p = 0; p < NumPhases; p++) begin
         write_frame_width(phase_widths[p]);
         // The final setting runs with both sides streaming flat out.
         if (p == NumPhases - 1) begin
            idle_enable = 1'b0;
         end
         for (int n = 0; n < PhaseItems; n++) begin
            // Once in a while the sender holds off until the core is empty.
            if (n == PhaseItems / 2 && p % 3 == 0) begin
               drain_results();
            end
            send_random_macropixel();
         end
      end

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_pixels.size() != 0 && wait_cycles < DrainLimit) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (DrainTail) @(negedge clock);
      if (pending_pixels.size() != 0) begin
         $error("%0d expected rsp items never arrived", pending_pixels.size());
         mismatch_count++;
      end

      $display("Converted %0d macropixels and checked %0d pixel pairs over %0d width settings.",
               macropixels_accepted, pairs_checked, width_settings);
      $display("Coefficient sets used: BT.709 for %0d items, BT.601 for %0d items.",
               bt709_count, bt601_count);
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("tb failed");
      $finish;
   end

endmodule
